@@ hw/rtl/stc_pkg.sv @@
// Shared types, token codes, character codes and operator lookup for the
// source character tokenizer. No dependencies.
`timescale 1ns / 1ps

package stc_pkg;

   localparam int POSITION_BITS_DEF = 16;
   localparam int MAX_TOKENS = 3;

   // token kinds: operators first, then the other token classes
   localparam logic [5:0] OP_INC       = 6'd0;
   localparam logic [5:0] OP_ADD_EQ    = 6'd1;
   localparam logic [5:0] OP_ADD       = 6'd2;
   localparam logic [5:0] OP_DEC       = 6'd3;
   localparam logic [5:0] OP_SUB_EQ    = 6'd4;
   localparam logic [5:0] OP_ARROW     = 6'd5;
   localparam logic [5:0] OP_SUB       = 6'd6;
   localparam logic [5:0] OP_POW_EQ    = 6'd7;
   localparam logic [5:0] OP_POW       = 6'd8;
   localparam logic [5:0] OP_MUL_EQ    = 6'd9;
   localparam logic [5:0] OP_MUL       = 6'd10;
   localparam logic [5:0] OP_IDIV_EQ   = 6'd11;
   localparam logic [5:0] OP_IDIV      = 6'd12;
   localparam logic [5:0] OP_DIV_EQ    = 6'd13;
   localparam logic [5:0] OP_DIV       = 6'd14;
   localparam logic [5:0] OP_EQ        = 6'd15;
   localparam logic [5:0] OP_FAT_ARROW = 6'd16;
   localparam logic [5:0] OP_ASSIGN    = 6'd17;
   localparam logic [5:0] OP_NE        = 6'd18;
   localparam logic [5:0] OP_NOT       = 6'd19;
   localparam logic [5:0] OP_LE        = 6'd20;
   localparam logic [5:0] OP_LT        = 6'd21;
   localparam logic [5:0] OP_GE        = 6'd22;
   localparam logic [5:0] OP_GT        = 6'd23;
   localparam logic [5:0] OP_LAND      = 6'd24;
   localparam logic [5:0] OP_AND       = 6'd25;
   localparam logic [5:0] OP_LOR       = 6'd26;
   localparam logic [5:0] OP_OR        = 6'd27;
   localparam logic [5:0] OP_LPAREN    = 6'd28;
   localparam logic [5:0] OP_RPAREN    = 6'd29;
   localparam logic [5:0] OP_LBRACK    = 6'd30;
   localparam logic [5:0] OP_RBRACK    = 6'd31;
   localparam logic [5:0] OP_LBRACE    = 6'd32;
   localparam logic [5:0] OP_RBRACE    = 6'd33;
   localparam logic [5:0] OP_DOT       = 6'd34;
   localparam logic [5:0] OP_COMMA     = 6'd35;
   localparam logic [5:0] OP_COLON     = 6'd36;
   localparam logic [5:0] OP_SEMI      = 6'd37;
   localparam logic [5:0] OP_QUEST     = 6'd38;
   localparam logic [5:0] OP_MOD       = 6'd39;
   localparam logic [5:0] K_IDENT      = 6'd40;
   localparam logic [5:0] K_INT        = 6'd41;
   localparam logic [5:0] K_FLOAT      = 6'd42;
   localparam logic [5:0] K_STRING     = 6'd43;
   localparam logic [5:0] K_NEWLINE    = 6'd44;
   localparam logic [5:0] K_BADSTR     = 6'd45;
   localparam logic [5:0] K_UNTERM     = 6'd46;
   localparam logic [5:0] K_UNKNOWN    = 6'd47;

   // character codes
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   // all tokens caused by one input item, slot 0 first
   typedef struct packed {
      logic [1:0]                  count;
      token_type [MAX_TOKENS-1:0] slots;
   } emit_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] kind;
   } op_hit_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
   endfunction

   function automatic logic ident_cont(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   // operators that can stand alone or open a longer operator
   function automatic op_hit_type op_alone(input logic [7:0] c);
      op_hit_type r;
      r.hit = 1'b1;
      case (c)
         CH_PLUS:  r.kind = OP_ADD;
         CH_MINUS: r.kind = OP_SUB;
         CH_STAR:  r.kind = OP_MUL;
         CH_SLASH: r.kind = OP_DIV;
         CH_EQ:    r.kind = OP_ASSIGN;
         CH_BANG:  r.kind = OP_NOT;
         CH_LT:    r.kind = OP_LT;
         CH_GT:    r.kind = OP_GT;
         CH_AMP:   r.kind = OP_AND;
         CH_PIPE:  r.kind = OP_OR;
         default: begin
            r.hit  = 1'b0;
            r.kind = K_UNKNOWN;
         end
      endcase
      return r;
   endfunction

   // operators that are always one character
   function automatic op_hit_type single_op(input logic [7:0] c);
      op_hit_type r;
      r.hit = 1'b1;
      case (c)
         CH_LPAREN:  r.kind = OP_LPAREN;
         CH_RPAREN:  r.kind = OP_RPAREN;
         CH_LBRACK:  r.kind = OP_LBRACK;
         CH_RBRACK:  r.kind = OP_RBRACK;
         CH_LBRACE:  r.kind = OP_LBRACE;
         CH_RBRACE:  r.kind = OP_RBRACE;
         CH_DOT:     r.kind = OP_DOT;
         CH_COMMA:   r.kind = OP_COMMA;
         CH_COLON:   r.kind = OP_COLON;
         CH_SEMI:    r.kind = OP_SEMI;
         CH_QUEST:   r.kind = OP_QUEST;
         CH_PERCENT: r.kind = OP_MOD;
         default: begin
            r.hit  = 1'b0;
            r.kind = K_UNKNOWN;
         end
      endcase
      return r;
   endfunction

   function automatic op_hit_type op_pair(input logic [7:0] a, input logic [7:0] b);
      op_hit_type r;
      r.hit  = 1'b0;
      r.kind = K_UNKNOWN;
      case (a)
         CH_PLUS: begin
            if (b == CH_PLUS) begin
               r.hit = 1'b1; r.kind = OP_INC;
            end else if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_ADD_EQ;
            end
         end
         CH_MINUS: begin
            if (b == CH_MINUS) begin
               r.hit = 1'b1; r.kind = OP_DEC;
            end else if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_SUB_EQ;
            end else if (b == CH_GT) begin
               r.hit = 1'b1; r.kind = OP_ARROW;
            end
         end
         CH_STAR: begin
            if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_MUL_EQ;
            end
         end
         CH_SLASH: begin
            if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_DIV_EQ;
            end
         end
         CH_EQ: begin
            if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_EQ;
            end else if (b == CH_GT) begin
               r.hit = 1'b1; r.kind = OP_FAT_ARROW;
            end
         end
         CH_BANG: begin
            if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_NE;
            end
         end
         CH_LT: begin
            if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_LE;
            end
         end
         CH_GT: begin
            if (b == CH_EQ) begin
               r.hit = 1'b1; r.kind = OP_GE;
            end
         end
         CH_AMP: begin
            if (b == CH_AMP) begin
               r.hit = 1'b1; r.kind = OP_LAND;
            end
         end
         CH_PIPE: begin
            if (b == CH_PIPE) begin
               r.hit = 1'b1; r.kind = OP_LOR;
            end
         end
         default: begin
            r.hit = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/stc_lex_core.sv @@
// Scanner state and token decision for one byte: holds the scan mode and
// positions, and gives every token the byte causes. Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_lex_core #(
   parameter int POSITION_BITS = stc_pkg::POSITION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        ch,
   input  logic              end_of_text,
   output stc_pkg::emit_type emit
);

   localparam int P = POSITION_BITS;
   localparam logic [P-1:0] POS_ONE = P'(1);
   localparam logic [P:0]   LEN_ONE = (P+1)'(1);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_NUMBER_DOT,
      MODE_STRING,
      MODE_OPERATOR,
      MODE_OPERATOR2
   } mode_type;

   mode_type     mode_ff, mode_in;
   logic [7:0]   p0_ff, p0_in;
   logic [P-1:0] begin_ff, begin_in;
   logic [P-1:0] pos_ff, pos_in;
   logic         float_ff, float_in;
   logic         bad_ff, bad_in;

   mode_type           st_mode;
   logic               st_v;
   stc_pkg::token_type st_tok;
   stc_pkg::token_type pre0, pre1;
   logic [1:0]         pre_n;
   logic               do_start;
   logic [1:0]         total;
   stc_pkg::op_hit_type alone_p0, pair_hit, alone_ch, single_ch;
   logic [P-1:0]       pos_m1;

   function automatic logic [15:0] clamp16(input logic [P:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic logic [P:0] span(input logic [P-1:0] endx,
                                       input logic [P-1:0] beg);
      return (endx > beg) ? {1'b0, endx - beg} : '0;
   endfunction

   function automatic stc_pkg::token_type mk(input logic [5:0] kind,
                                             input logic [P-1:0] start,
                                             input logic [P:0] len);
      stc_pkg::token_type t;
      t.kind   = kind;
      t.start  = clamp16({1'b0, start});
      t.length = clamp16(len);
      t.last   = 1'b0;
      return t;
   endfunction

   assign alone_p0  = stc_pkg::op_alone(p0_ff);
   assign pair_hit  = stc_pkg::op_pair(p0_ff, ch);
   assign alone_ch  = stc_pkg::op_alone(ch);
   assign single_ch = stc_pkg::single_op(ch);
   assign pos_m1    = pos_ff - POS_ONE;

   // what a byte does when it opens a new token
   always_comb begin
      st_mode = MODE_IDLE;
      st_v    = 1'b0;
      st_tok  = mk(stc_pkg::K_UNKNOWN, pos_ff, LEN_ONE);
      if (stc_pkg::is_blank(ch)) begin
         st_v = 1'b0;
      end else if (ch == stc_pkg::CH_LF) begin
         st_v   = 1'b1;
         st_tok = mk(stc_pkg::K_NEWLINE, pos_ff, LEN_ONE);
      end else if (ch == stc_pkg::CH_QUOTE) begin
         st_mode = MODE_STRING;
      end else if (stc_pkg::is_alpha(ch) || ch == stc_pkg::CH_UNDER) begin
         st_mode = MODE_IDENT;
      end else if (stc_pkg::is_digit(ch)) begin
         st_mode = MODE_NUMBER;
      end else if (alone_ch.hit) begin
         st_mode = MODE_OPERATOR;
      end else begin
         st_v   = 1'b1;
         st_tok = mk(single_ch.hit ? single_ch.kind : stc_pkg::K_UNKNOWN,
                     pos_ff, LEN_ONE);
      end
   end

   // tokens closed by this byte, then the new state
   always_comb begin
      mode_in  = mode_ff;
      p0_in    = p0_ff;
      begin_in = begin_ff;
      float_in = float_ff;
      bad_in   = bad_ff;
      pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + POS_ONE;
      pre_n    = 2'd0;
      pre0     = mk(stc_pkg::K_UNKNOWN, pos_ff, LEN_ONE);
      pre1     = mk(stc_pkg::OP_DOT, pos_m1, LEN_ONE);
      do_start = 1'b0;

      if (end_of_text) begin
         case (mode_ff)
            MODE_IDENT: begin
               pre_n = 2'd1;
               pre0  = mk(stc_pkg::K_IDENT, begin_ff, span(pos_ff, begin_ff));
            end
            MODE_NUMBER: begin
               pre_n = 2'd1;
               pre0  = mk(float_ff ? stc_pkg::K_FLOAT : stc_pkg::K_INT, begin_ff,
                          span(pos_ff, begin_ff));
            end
            MODE_NUMBER_DOT: begin
               pre_n = 2'd2;
               pre0  = mk(stc_pkg::K_INT, begin_ff, span(pos_m1, begin_ff));
            end
            MODE_STRING: begin
               pre_n = 2'd1;
               pre0  = mk(stc_pkg::K_UNTERM, begin_ff, span(pos_ff, begin_ff));
            end
            MODE_OPERATOR2: begin
               pre_n = 2'd1;
               pre0  = mk((p0_ff == stc_pkg::CH_STAR) ? stc_pkg::OP_POW
                                                       : stc_pkg::OP_IDIV,
                          begin_ff, (P+1)'(2));
            end
            MODE_OPERATOR: begin
               pre_n = 2'd1;
               pre0  = mk(alone_p0.hit ? alone_p0.kind : stc_pkg::K_UNKNOWN,
                          begin_ff, LEN_ONE);
            end
            default: begin
               pre_n = 2'd0;
            end
         endcase
         // back to the reset state: next byte is position zero
         mode_in  = MODE_IDLE;
         p0_in    = '0;
         begin_in = '0;
         pos_in   = '0;
         float_in = 1'b0;
         bad_in   = 1'b0;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!stc_pkg::ident_cont(ch)) begin
                  pre_n    = 2'd1;
                  pre0     = mk(stc_pkg::K_IDENT, begin_ff, span(pos_ff, begin_ff));
                  do_start = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (stc_pkg::is_digit(ch)) begin
                  mode_in = MODE_NUMBER;
               end else if (ch == stc_pkg::CH_DOT && !float_ff) begin
                  mode_in = MODE_NUMBER_DOT;
               end else begin
                  pre_n    = 2'd1;
                  pre0     = mk(float_ff ? stc_pkg::K_FLOAT : stc_pkg::K_INT,
                                begin_ff, span(pos_ff, begin_ff));
                  do_start = 1'b1;
               end
            end
            MODE_NUMBER_DOT: begin
               if (stc_pkg::is_digit(ch)) begin
                  float_in = 1'b1;
                  mode_in  = MODE_NUMBER;
               end else begin
                  // integer, then the dot on its own, then this byte afresh
                  pre_n    = 2'd2;
                  pre0     = mk(stc_pkg::K_INT, begin_ff, span(pos_m1, begin_ff));
                  do_start = 1'b1;
               end
            end
            MODE_STRING: begin
               if (ch == stc_pkg::CH_QUOTE) begin
                  pre_n   = 2'd1;
                  pre0    = mk(bad_ff ? stc_pkg::K_BADSTR : stc_pkg::K_STRING,
                               begin_ff, span(pos_ff, begin_ff) + LEN_ONE);
                  mode_in = MODE_IDLE;
               end else if (ch == stc_pkg::CH_LF || ch == stc_pkg::CH_CR) begin
                  bad_in = 1'b1;
               end
            end
            MODE_OPERATOR2: begin
               pre_n = 2'd1;
               if (ch == stc_pkg::CH_EQ) begin
                  pre0    = mk((p0_ff == stc_pkg::CH_STAR) ? stc_pkg::OP_POW_EQ
                                                            : stc_pkg::OP_IDIV_EQ,
                               begin_ff, (P+1)'(3));
                  mode_in = MODE_IDLE;
               end else begin
                  pre0     = mk((p0_ff == stc_pkg::CH_STAR) ? stc_pkg::OP_POW
                                                             : stc_pkg::OP_IDIV,
                                begin_ff, (P+1)'(2));
                  do_start = 1'b1;
               end
            end
            MODE_OPERATOR: begin
               if ((p0_ff == stc_pkg::CH_STAR || p0_ff == stc_pkg::CH_SLASH) &&
                   ch == p0_ff) begin
                  mode_in = MODE_OPERATOR2;
               end else if (pair_hit.hit) begin
                  pre_n   = 2'd1;
                  pre0    = mk(pair_hit.kind, begin_ff, (P+1)'(2));
                  mode_in = MODE_IDLE;
               end else begin
                  pre_n    = 2'd1;
                  pre0     = mk(alone_p0.hit ? alone_p0.kind : stc_pkg::K_UNKNOWN,
                                begin_ff, LEN_ONE);
                  do_start = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         if (do_start) begin
            mode_in  = st_mode;
            begin_in = pos_ff;
            p0_in    = ch;
            float_in = 1'b0;
            bad_in   = 1'b0;
         end
      end
   end

   // pack closed tokens first, then the token the byte itself gives
   always_comb begin
      total = pre_n + {1'b0, do_start & st_v};
      emit.count    = total;
      emit.slots[0] = (pre_n != 2'd0) ? pre0 : st_tok;
      emit.slots[1] = (pre_n == 2'd2) ? pre1 : st_tok;
      emit.slots[2] = st_tok;
      emit.slots[0].last = (total == 2'd1);
      emit.slots[1].last = (total == 2'd2);
      emit.slots[2].last = (total == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         p0_ff    <= '0;
         begin_ff <= '0;
         pos_ff   <= '0;
         float_ff <= 1'b0;
         bad_ff   <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         p0_ff    <= p0_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         float_ff <= float_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

@@ hw/rtl/source_char_tokenizer.sv @@
// The first token of a byte is offered on rsp_ the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one token and
// rsp_ready stays high; a byte giving n tokens (n up to 3) holds req_ready low
// until the token buffer drains, one token per rsp_ handshake.
// Reset (synchronous, active high) empties the token buffer and starts a new text.
// Top level of the source character tokenizer; uses stc_pkg and stc_lex_core.
`timescale 1ns / 1ps

module source_char_tokenizer #(
   parameter int POSITION_BITS = stc_pkg::POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last
);

   localparam int N = stc_pkg::MAX_TOKENS;

   stc_pkg::emit_type             emit;
   stc_pkg::token_type [N-1:0]    buf_ff, buf_in;
   logic [1:0]                    cnt_ff, cnt_in;
   logic                          take;
   logic                          pop;

   stc_lex_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .ch          (req_ch),
      .end_of_text (req_end_of_text),
      .emit        (emit)
   );

   // take a new byte once the buffer is empty or its last token leaves now
   assign req_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign take      = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_token_kind   = buf_ff[0].kind;
   assign rsp_token_start  = buf_ff[0].start;
   assign rsp_token_length = buf_ff[0].length;
   assign rsp_last         = buf_ff[0].last;

   always_comb begin
      cnt_in = cnt_ff;
      buf_in = buf_ff;
      if (take) begin
         cnt_in = emit.count;
         buf_in = emit.slots;
      end else if (pop) begin
         // advance the queue by one token
         cnt_in    = cnt_ff - 2'd1;
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule
